>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the lru key/value cache
// item and result beat layouts, operation codes and register widths
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } result_t;

endpackage

>>> rtl/lkv_match.sv
// ----------------------------------------------------------------------------
// lkv_match: parallel key compare
// compares the lookup key against every valid entry at once
// ----------------------------------------------------------------------------
module lkv_match #(
  parameter int ENTRIES = 16
) (
  input  logic [lkv_pkg::DATA_W-1:0] key,
  input  logic [lkv_pkg::DATA_W-1:0] key_store [ENTRIES],
  input  logic [ENTRIES-1:0]         entry_valid,
  output logic [ENTRIES-1:0]         match
);
  import lkv_pkg::*;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (key_store[i] == key);
    end
  end

endmodule

>>> rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: entry array with lru ranks
// holds keys, values, valid marks, ranks and occupancy, and applies one
// get or put per exec cycle
// ----------------------------------------------------------------------------
module lkv_store #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      exec,
  input  lkv_pkg::item_t            item,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::result_t          result
);
  import lkv_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [DATA_W-1:0] key_store   [ENTRIES];
  logic [DATA_W-1:0] value_store [ENTRIES];
  logic [RANK_W-1:0] rank        [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [OCC_W-1:0]   occupancy;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] valid_kept;
  logic [ENTRIES-1:0] free_slot;
  logic [ENTRIES-1:0] insert_sel;
  logic [RANK_W-1:0]  hit_rank;
  logic [RANK_W-1:0]  oldest_rank;
  logic [DATA_W-1:0]  hit_value;
  logic [CMP_W-1:0]   cap_sat;
  logic               hit;
  logic               is_put;
  logic               do_evict;
  logic               do_insert;

  lkv_match #(.ENTRIES(ENTRIES)) u_match (
    .key         (item.key),
    .key_store   (key_store),
    .entry_valid (entry_valid),
    .match       (match)
  );

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_rank  = hit_rank | rank[i];
        hit_value = hit_value | value_store[i];
      end
    end
  end

  assign hit     = |match;
  assign is_put  = (item.mode == MODE_PUT);
  assign cap_sat = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);

  // valid ranks are always a permutation of 0..occupancy-1
  assign oldest_rank = RANK_W'(occupancy - 1'b1);
  assign do_evict    = is_put && !hit && (CMP_W'(occupancy) >= cap_sat) && (occupancy != '0);
  assign do_insert   = is_put && !hit && (cap_sat != '0);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = entry_valid[i] && (rank[i] == oldest_rank);
    end
  end

  assign valid_kept = entry_valid & ~(do_evict ? victim : '0);
  assign free_slot  = ~valid_kept;
  // lowest free entry
  assign insert_sel = free_slot & (~free_slot + ENTRIES'(1));

  assign result.hit        = hit;
  assign result.read_value = (hit && !is_put) ? hit_value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (exec) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank[i] <= '0;
          end else if (entry_valid[i] && rank[i] < hit_rank) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end else if (is_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (do_insert && insert_sel[i]) begin
            entry_valid[i] <= 1'b1;
            rank[i]        <= '0;
          end else if (!valid_kept[i]) begin
            entry_valid[i] <= 1'b0;
            rank[i]        <= '0;
          end else if (do_insert) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        occupancy <= occupancy - OCC_W'(do_evict) + OCC_W'(do_insert);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && is_put) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          value_store[i] <= item.value;
        end else if (!hit && do_insert && insert_sel[i]) begin
          key_store[i]   <= item.key;
          value_store[i] <= item.value;
        end
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    OCC_W'(ENTRIES) >= occupancy)
    else $error("occupancy above entry count");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupancy))
    else $error("occupancy disagrees with valid marks");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    exec && do_insert |=> occupancy != '0)
    else $error("insert left the store empty");

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, lru replacement
// path: the accepted input beat is registered, and once executed its result beat is registered
// throughput: one get or put per cycle while the response channel does not stall, bounded by
//   the combinational compare across all entries plus the rank update of the entry array
// reset: valid marks, ranks and occupancy clear at once, capacity returns to
//   16, key and value storage is left as is
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel, capacity register only
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic signed [lkv_pkg::DATA_W-1:0] key,
  input  logic signed [lkv_pkg::DATA_W-1:0] value,
  // response channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic signed [lkv_pkg::DATA_W-1:0] read_value
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity;
  item_t            item_q;
  logic             item_valid;
  result_t          result_q;
  result_t          result;
  logic             exec;

  // the request stage runs, if it holds a request, whenever the result register is free or
  // is being drained in the same cycle
  assign exec      = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || exec;
  assign cfg_ready = 1'b1;

  lkv_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst      (rst),
    .exec     (exec),
    .item     (item_q),
    .capacity (capacity),
    .result   (result)
  );

  // control: beat valids and the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      capacity   <= CAP_RESET;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (exec) begin
        item_valid <= 1'b0;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // payload: input beat and result beat, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.mode  <= mode;
      item_q.key   <= key;
      item_q.value <= value;
    end
    if (exec) begin
      result_q <= result;
    end
  end

  assign hit        = result_q.hit;
  assign read_value = result_q.read_value;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_q))
    else $error("result beat dropped while stalled");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !exec |=> item_valid && $stable(item_q))
    else $error("pending request lost before execution");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> out_valid)
    else $error("executed request produced no result beat");

endmodule

>>> bench/lru_key_value_cache_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test: self-checking bench for the lru key/value cache
// bursty request driver and stalling response monitor around a lru predictor,
// capacity swept across phases between drained points, one long output stall
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int CACHE_ENTRIES = 16;
  localparam int DRAIN_CYCLES  = 6;       // margin after the last response is back
  localparam int HOLD_CYCLES   = 300;     // long output stall to back up the input
  localparam int CYCLE_LIMIT   = 200000;

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration channel
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  // request channel
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     mode     = MODE_GET;
  logic signed [DATA_W-1:0] key      = '0;
  logic signed [DATA_W-1:0] value    = '0;

  // response channel
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  lru_key_value_cache #(
    .ENTRIES(CACHE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .read_value(read_value)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // lru predictor state, a private copy of the cache contents
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] cache_keys   [CACHE_ENTRIES];
  logic signed [DATA_W-1:0] cache_values [CACHE_ENTRIES];
  logic                     cache_valid  [CACHE_ENTRIES];
  int unsigned              cache_rank   [CACHE_ENTRIES];   // 0 is most recent
  int unsigned              cache_count  = 0;
  int unsigned              cache_capacity = CAP_RESET;

  // request beats waiting to be offered, responses waiting to arrive
  item_t   request_queue[$];
  result_t expected_results[$];

  int error_count = 0;
  int cycle_count = 0;

  // sender burst shaping
  int    burst_left = 1;
  int    gap_left   = 0;
  item_t offered_item;

  // receiver stall shaping
  logic ready_phase = 1'b1;
  int   run_left    = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;

  // key pool so that gets and puts keep landing on stored keys
  logic signed [DATA_W-1:0] key_pool[32];

  // one get or put applied to the predicted cache, returns the response beat
  function automatic result_t lru_access(item_t req);
    result_t     res;
    int          found;
    int          victim;
    int          slot;
    int          i;
    int unsigned eff_cap;
    int unsigned old_rank;
    int unsigned worst;
    res.hit        = 1'b0;
    res.read_value = '0;
    // capacity above the entry count saturates
    eff_cap = (cache_capacity > CACHE_ENTRIES) ? CACHE_ENTRIES : cache_capacity;
    found = -1;
    for (i = 0; i < CACHE_ENTRIES; i++)
      if (found < 0 && cache_valid[i] && cache_keys[i] == req.key) found = i;
    if (found >= 0) begin
      // hit: entries newer than this one age by one, this one becomes newest
      res.hit  = 1'b1;
      old_rank = cache_rank[found];
      for (i = 0; i < CACHE_ENTRIES; i++)
        if (cache_valid[i] && i != found && cache_rank[i] < old_rank) cache_rank[i]++;
      cache_rank[found] = 0;
      if (req.mode == MODE_GET) res.read_value = cache_values[found];
      else cache_values[found] = req.value;
    end else if (req.mode == MODE_PUT) begin
      // full (or over a lowered capacity): drop the oldest entry, only one
      if (cache_count >= eff_cap && cache_count > 0) begin
        victim = -1;
        worst  = 0;
        for (i = 0; i < CACHE_ENTRIES; i++)
          if (cache_valid[i] && (victim < 0 || cache_rank[i] > worst)) begin
            victim = i;
            worst  = cache_rank[i];
          end
        if (victim >= 0) begin
          cache_valid[victim] = 1'b0;
          cache_rank[victim]  = 0;
          if (cache_count > 0) cache_count--;
        end
      end
      // zero capacity stores nothing; otherwise lowest free slot takes the pair
      if (eff_cap > 0) begin
        slot = -1;
        for (i = 0; i < CACHE_ENTRIES; i++)
          if (slot < 0 && !cache_valid[i]) slot = i;
        if (slot >= 0) begin
          for (i = 0; i < CACHE_ENTRIES; i++)
            if (cache_valid[i]) cache_rank[i]++;
          cache_keys[slot]   = req.key;
          cache_values[slot] = req.value;
          cache_valid[slot]  = 1'b1;
          cache_rank[slot]   = 0;
          cache_count++;
        end
      end
    end
    return res;
  endfunction

  task automatic push_item(logic m, logic signed [DATA_W-1:0] k, logic signed [DATA_W-1:0] v);
    item_t req;
    req.mode  = m;
    req.key   = k;
    req.value = v;
    request_queue.insert(request_queue.size(), req);
  endtask

  // block until every request is sent and every response is back, then a margin
  task automatic wait_until_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one beat on the configuration channel, only called while idle
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid      <= 1'b0;
    cache_capacity  = cap;
  endtask

  // random phase: mostly keys from a pool a bit larger than the capacity,
  // some fully random keys for bit coverage
  task automatic queue_random_phase(int count, int unsigned cap);
    int unsigned eff_cap;
    int          pool_size;
    int          n;
    logic signed [DATA_W-1:0] k;
    eff_cap   = (cap > CACHE_ENTRIES) ? CACHE_ENTRIES : cap;
    pool_size = eff_cap + 6;
    if (pool_size > 32) pool_size = 32;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, pool_size - 1)];
      push_item($urandom_range(0, 1) ? MODE_PUT : MODE_GET, k, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: offers queued beats in bursts, predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    logic  accepted;
    logic  offer;
    item_t next_item;
    accepted = in_valid && in_ready;
    offer    = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (accepted) expected_results.insert(expected_results.size(), lru_access(offered_item));
      // a new beat only once the current one is gone
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          offer        = 1'b1;
          next_item    = request_queue[0];
          request_queue.delete(0);
          offered_item = next_item;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // a fair share of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= offer;
        if (offer) begin
          mode  <= next_item.mode;
          key   <= next_item.key;
          value <= next_item.value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor: checks each accepted beat, drives its own stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    logic    next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: response beat with none expected, hit=%0b read_value=%h",
                   $time, hit, read_value);
          error_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
            error_count++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, want.read_value, read_value);
            error_count++;
          end
        end
      end
      // one long hold-off while plenty of requests are still queued
      if (!hold_done && request_queue.size() > 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        if (run_left == 0) begin
          if (ready_phase && $urandom_range(0, 2) != 0) begin
            ready_phase = 1'b0;
            run_left    = $urandom_range(1, 5);
          end else begin
            ready_phase = 1'b1;
            run_left    = $urandom_range(1, 12);
          end
        end
        run_left--;
        next_ready = ready_phase;
      end
      out_ready <= next_ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    for (i = 0; i < CACHE_ENTRIES; i++) begin
      cache_keys[i]   = '0;
      cache_values[i] = '0;
      cache_valid[i]  = 1'b0;
      cache_rank[i]   = 0;
    end
    key_pool[0] = 32'sh0000_0000;
    key_pool[1] = 32'shffff_ffff;
    key_pool[2] = 32'sh8000_0000;
    key_pool[3] = 32'sh7fff_ffff;
    for (i = 4; i < 32; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // two entries: fill, refresh by get, evict the older, overwrite on put
    set_capacity(5'd2);
    push_item(MODE_GET, 32'sh0000_0000, 32'sh0000_0000);    // get on empty cache
    push_item(MODE_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
    push_item(MODE_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
    push_item(MODE_GET, 32'sh8000_0000, 32'sh0000_0000);    // hit, now newest
    push_item(MODE_PUT, 32'sh0000_0000, 32'shffff_ffff);    // evicts max key
    push_item(MODE_GET, 32'sh7fff_ffff, 32'sh0000_0000);    // miss after eviction
    push_item(MODE_PUT, 32'sh0000_0000, 32'sh1234_5678);    // put hit, reads zero
    push_item(MODE_GET, 32'sh0000_0000, 32'shffff_ffff);    // value ignored on get
    push_item(MODE_GET, 32'shffff_ffff, 32'shffff_ffff);    // miss with all ones
    wait_until_drained();

    // zero capacity: puts on new keys drain the store and keep nothing
    set_capacity(5'd0);
    push_item(MODE_PUT, 32'sh0000_0005, 32'sh0000_0001);
    push_item(MODE_PUT, 32'sh0000_0006, 32'sh0000_0002);
    push_item(MODE_PUT, 32'sh0000_0007, 32'sh0000_0003);
    push_item(MODE_GET, 32'sh0000_0007, 32'sh0000_0000);
    push_item(MODE_GET, 32'sh8000_0000, 32'sh0000_0000);
    wait_until_drained();

    // single entry
    set_capacity(5'd1);
    push_item(MODE_PUT, 32'sh0000_00aa, 32'sh0bad_cafe);
    push_item(MODE_PUT, 32'sh0000_00bb, 32'sh7fff_ffff);
    push_item(MODE_GET, 32'sh0000_00aa, 32'sh0000_0000);
    push_item(MODE_GET, 32'sh0000_00bb, 32'sh0000_0000);
    wait_until_drained();

    // random phases over a spread of capacities; 3 after 31 lowers it below
    // a full store, 31 saturates to the entry count
    set_capacity(5'd16); queue_random_phase(60, 16); wait_until_drained();
    set_capacity(5'd5);  queue_random_phase(50, 5);  wait_until_drained();
    set_capacity(5'd1);  queue_random_phase(40, 1);  wait_until_drained();
    set_capacity(5'd31); queue_random_phase(60, 31); wait_until_drained();
    set_capacity(5'd3);  queue_random_phase(50, 3);  wait_until_drained();
    set_capacity(5'd0);  queue_random_phase(25, 0);  wait_until_drained();
    set_capacity(5'd9);  queue_random_phase(50, 9);  wait_until_drained();
    set_capacity(5'd2);  queue_random_phase(40, 2);  wait_until_drained();
    set_capacity(5'd16); queue_random_phase(30, 16); wait_until_drained();

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
